/* rtl/pbbt_pkg.sv */
// Shared types and constants for the PLY binary body triangulator.
// No dependencies; used by every module under rtl/.
package pbbt_pkg;

    // Width of the vertex / face counters.
    localparam int COUNT_BITS = 24;
    // Width of the configuration data port (widest register).
    localparam int CFG_BITS   = 24;
    // Indices read before a face starts emitting triangles.
    localparam logic [7:0] CORNERS = 8'd3;

    // Configuration register indexes.
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_FACE_COUNT   = 1'b1;

    // Result kinds.
    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    // Body section, one-hot.
    typedef enum logic [3:0] {
        PH_VERT   = 4'b0001,
        PH_FCOUNT = 4'b0010,
        PH_FIDX   = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    // One result word moved to the output stage.
    typedef struct packed {
        logic        kind;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic        fin;
    } result_t;

    // Fit a configuration value to the counter width (zero extend or truncate).
    function automatic logic [COUNT_BITS-1:0] to_count(input logic [CFG_BITS-1:0] v);
        logic [63:0] wide;
        wide = {{(64-CFG_BITS){1'b0}}, v};
        return wide[COUNT_BITS-1:0];
    endfunction

endpackage

/* rtl/pbbt_parser.sv */
// Body parser: section/word state and the single-step next-state logic.
// Depends on pbbt_pkg.
module pbbt_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,        // commit this byte
    input  logic [7:0]                       data_byte,
    input  logic                             body_start,
    input  logic [pbbt_pkg::COUNT_BITS-1:0]  vertex_count,
    input  logic [pbbt_pkg::COUNT_BITS-1:0]  face_count,
    output logic                             res_valid,
    output pbbt_pkg::result_t                res
);

    pbbt_pkg::phase_t                 phase_reg, phase_next, phase_cur;
    logic [1:0]                       bw_reg, bw_next, bw_cur;
    logic [23:0]                      part_reg, part_next, part_cur;
    logic [1:0]                       wig_reg, wig_next, wig_cur;
    logic [31:0]                      first_reg, first_next, first_cur;
    logic [31:0]                      second_reg, second_next, second_cur;
    logic [pbbt_pkg::COUNT_BITS-1:0]  done_reg, done_next, done_cur;
    logic [7:0]                       corn_reg, corn_next, corn_cur;
    logic [31:0]                      word;
    logic [pbbt_pkg::COUNT_BITS-1:0]  done_inc;

    always_comb
    begin
        // body_start clears everything before the byte is used
        if (body_start)
        begin
            phase_cur  = pbbt_pkg::PH_VERT;
            bw_cur     = '0;
            part_cur   = '0;
            wig_cur    = '0;
            first_cur  = '0;
            second_cur = '0;
            done_cur   = '0;
            corn_cur   = '0;
        end
        else
        begin
            phase_cur  = phase_reg;
            bw_cur     = bw_reg;
            part_cur   = part_reg;
            wig_cur    = wig_reg;
            first_cur  = first_reg;
            second_cur = second_reg;
            done_cur   = done_reg;
            corn_cur   = corn_reg;
        end

        phase_next  = phase_cur;
        bw_next     = bw_cur;
        part_next   = part_cur;
        wig_next    = wig_cur;
        first_next  = first_cur;
        second_next = second_cur;
        done_next   = done_cur;
        corn_next   = corn_cur;

        word     = {data_byte, part_cur};
        done_inc = done_cur + 1'b1;

        res_valid  = 1'b0;
        res.kind   = pbbt_pkg::KIND_VERTEX;
        res.word_a = first_cur;
        res.word_b = second_cur;
        res.word_c = word;
        res.fin    = 1'b0;

        case (phase_cur)
            pbbt_pkg::PH_FCOUNT:
            begin
                corn_next  = data_byte;
                wig_next   = 2'd0;
                bw_next    = 2'd0;
                part_next  = '0;
                phase_next = pbbt_pkg::PH_FIDX;
            end
            pbbt_pkg::PH_VERT, pbbt_pkg::PH_FIDX:
            begin
                if (bw_cur != 2'd3)
                begin
                    // low three bytes of a little-endian word
                    part_next[{bw_cur, 3'b000} +: 8] = data_byte;
                    bw_next = bw_cur + 2'd1;
                end
                else
                begin
                    bw_next   = 2'd0;
                    part_next = '0;
                    if (wig_cur == 2'd0)
                    begin
                        first_next = word;
                        wig_next   = 2'd1;
                    end
                    else if (wig_cur == 2'd1)
                    begin
                        second_next = word;
                        wig_next    = 2'd2;
                    end
                    else if (phase_cur == pbbt_pkg::PH_VERT)
                    begin
                        res_valid = 1'b1;
                        wig_next  = 2'd0;
                        done_next = done_inc;
                        if (done_inc >= vertex_count)
                        begin
                            done_next = '0;
                            if (face_count == '0)
                            begin
                                phase_next = pbbt_pkg::PH_DONE;
                                res.fin    = 1'b1;
                            end
                            else
                            begin
                                phase_next = pbbt_pkg::PH_FCOUNT;
                            end
                        end
                    end
                    else
                    begin
                        // one fan triangle: centre, previous, newest
                        res_valid = 1'b1;
                        res.kind  = pbbt_pkg::KIND_TRIANGLE;
                        if (corn_cur > pbbt_pkg::CORNERS)
                        begin
                            corn_next   = corn_cur - 8'd1;
                            second_next = word;
                            wig_next    = 2'd2;
                        end
                        else
                        begin
                            wig_next  = 2'd0;
                            done_next = done_inc;
                            if (done_inc >= face_count)
                            begin
                                phase_next = pbbt_pkg::PH_DONE;
                                res.fin    = 1'b1;
                            end
                            else
                            begin
                                phase_next = pbbt_pkg::PH_FCOUNT;
                            end
                        end
                    end
                end
            end
            default:
            begin
                // after the body: ignore bytes
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= pbbt_pkg::PH_VERT;
            bw_reg     <= '0;
            part_reg   <= '0;
            wig_reg    <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            done_reg   <= '0;
            corn_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            bw_reg     <= bw_next;
            part_reg   <= part_next;
            wig_reg    <= wig_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            done_reg   <= done_next;
            corn_reg   <= corn_next;
        end
    end

endmodule

/* rtl/pbbt_out_reg.sv */
// Output result register with stream handshake toward the master side.
// Depends on pbbt_pkg.
module pbbt_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  pbbt_pkg::result_t  res,
    output logic               can_load,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [95:0]        m_tdata,   // word_a [31:0], word_b [63:32], word_c [95:64]
    output logic               m_tuser,   // item_kind
    output logic               m_tlast    // final_res
);

    logic              valid_reg;
    pbbt_pkg::result_t data_reg;

    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.word_c, data_reg.word_b, data_reg.word_a};
    assign m_tuser  = data_reg.kind;
    assign m_tlast  = data_reg.fin;

endmodule

/* rtl/ply_binary_body_triangulator.sv */
// Top level of the PLY binary little-endian body triangulator.
// Depends on pbbt_pkg, pbbt_parser and pbbt_out_reg.
//
// Feed the body of a binary little-endian PLY mesh one byte per word on the
// slave side; set s_tuser on the first byte of each body to clear all
// counters. The block first reads vertex_count vertices (three 4-byte words
// each) and sends each as a vertex word (m_tuser = 0, raw x/y/z float bits in
// m_tdata). It then reads face_count faces, each a count byte and then 4-byte
// indices, and sends one triangle word (m_tuser = 1) per index from the third
// on: fan centre, previous index, newest index. A face always reads at least
// three indices. m_tlast marks the last word of the body; further bytes are
// dropped until the next s_tuser. Rate: one byte per clock, sustained, with
// m_tready high. A byte lands in the input register at the edge that accepts
// it; the one-step parser loads its result into the output register when that
// register can take one, and m_tvalid rises with it. A byte waits in the input
// register while the output register holds a word that m_tready has not yet
// taken. The parser step is the only logic between those two registers.
// The user writes vertex_count and face_count via cfg_we/cfg_index/cfg_data
// only while the block is idle; the block does not enforce this. Reset: 1 and 0.
module ply_binary_body_triangulator (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [pbbt_pkg::CFG_BITS-1:0] cfg_data,
    // byte stream in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // data_byte [7:0]
    input  logic                          s_tuser,   // body_start
    // results out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [95:0]                   m_tdata,   // word_a, word_b, word_c
    output logic                          m_tuser,   // item_kind
    output logic                          m_tlast    // final_res
);

    logic [pbbt_pkg::COUNT_BITS-1:0] vcount_reg;
    logic [pbbt_pkg::COUNT_BITS-1:0] fcount_reg;

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_start_reg;

    logic              can_load;
    logic              step;
    logic              res_valid;
    pbbt_pkg::result_t res;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= pbbt_pkg::COUNT_BITS'(1);
            fcount_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pbbt_pkg::CFG_VERTEX_COUNT: vcount_reg <= pbbt_pkg::to_count(cfg_data);
                pbbt_pkg::CFG_FACE_COUNT:   fcount_reg <= pbbt_pkg::to_count(cfg_data);
                default:                    ;
            endcase
        end
    end

    // the held byte is processed once the output stage can take a result
    assign step     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    pbbt_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_byte    (in_byte_reg),
        .body_start   (in_start_reg),
        .vertex_count (vcount_reg),
        .face_count   (fcount_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    pbbt_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step && res_valid),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* tb/ply_binary_body_triangulator_tb.sv */
// Self-checking testbench for ply_binary_body_triangulator: streams PLY body bytes,
// predicts every vertex / triangle word in its own parser model and checks the outputs.
// Depends on rtl/pbbt_pkg.sv and rtl/ply_binary_body_triangulator.sv.
module ply_binary_body_triangulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbbt_pkg::*;

    // cycles with no word moving on either side before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // settle time after the last expected word; covers the two-stage pipeline
    localparam int DRAIN_CYCLES   = 4;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_index = CFG_VERTEX_COUNT;
    logic [CFG_BITS-1:0] cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;   // data_byte [7:0]
    logic                s_tuser   = 1'b0; // body_start
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [95:0]         m_tdata;          // word_a [31:0], word_b [63:32], word_c [95:64]
    logic                m_tuser;          // item_kind
    logic                m_tlast;          // final_res

    ply_binary_body_triangulator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Parser model: mirrors the block's body state, stepped once per
    // accepted byte. Words it produces go to pending_results in order.
    // ------------------------------------------------------------------
    logic [COUNT_BITS-1:0] n_vertices;     // vertex_count register copy
    logic [COUNT_BITS-1:0] n_faces;        // face_count register copy

    phase_t                body_phase;
    logic [1:0]            byte_pos;       // byte within the 4-byte LE word
    logic [23:0]           low_bytes;      // first three bytes of that word
    logic [7:0]            word_pos;       // word within vertex / triangle
    logic [31:0]           fan_first;      // x, or fan centre index
    logic [31:0]           fan_prev;       // y, or previous index
    logic [COUNT_BITS-1:0] done_count;     // vertices or faces finished
    logic [7:0]            corners_left;   // count byte of the current face

    result_t               pending_results[$];

    int                    error_count = 0;
    int                    bytes_sent  = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    quiet_cycles  = 0;
    logic [7:0]            body_bytes[$];  // body being assembled before sending

    task automatic clear_parse_state();
        body_phase   = PH_VERT;
        byte_pos     = '0;
        low_bytes    = '0;
        word_pos     = '0;
        fan_first    = '0;
        fan_prev     = '0;
        done_count   = '0;
        corners_left = '0;
    endtask

    task automatic reset_parser_model();
        n_vertices = COUNT_BITS'(1);
        n_faces    = '0;
        clear_parse_state();
    endtask

    task automatic predict_body_byte(input logic [7:0] b, input logic start);
        logic [31:0] full;
        result_t     r;
        if (start)
            clear_parse_state();
        if (body_phase == PH_DONE)
            return;
        // face header: count byte, then indices start over
        if (body_phase == PH_FCOUNT)
        begin
            corners_left = b;
            word_pos     = '0;
            byte_pos     = '0;
            low_bytes    = '0;
            body_phase   = PH_FIDX;
            return;
        end
        if (byte_pos != 2'd3)
        begin
            low_bytes[8*byte_pos +: 8] = b;
            byte_pos = byte_pos + 2'd1;
            return;
        end
        full      = {b, low_bytes};
        byte_pos  = '0;
        low_bytes = '0;
        if (word_pos == 8'd0)
        begin
            fan_first = full;
            word_pos  = 8'd1;
            return;
        end
        if (word_pos == 8'd1)
        begin
            fan_prev = full;
            word_pos = 8'd2;
            return;
        end
        r.word_a = fan_first;
        r.word_b = fan_prev;
        r.word_c = full;
        r.fin    = 1'b0;
        if (body_phase == PH_VERT)
        begin
            r.kind     = KIND_VERTEX;
            word_pos   = '0;
            done_count = done_count + 1'b1;
            // ">=" so a zero count still closes after one vertex
            if (done_count >= n_vertices)
            begin
                done_count = '0;
                if (n_faces == '0)
                begin
                    body_phase = PH_DONE;
                    r.fin      = 1'b1;
                end
                else
                    body_phase = PH_FCOUNT;
            end
        end
        else
        begin
            r.kind = KIND_TRIANGLE;
            if (corners_left > CORNERS)
            begin
                // fan continues: newest index becomes the previous one
                corners_left = corners_left - 8'd1;
                fan_prev     = full;
                word_pos     = 8'd2;
            end
            else
            begin
                word_pos   = '0;
                done_count = done_count + 1'b1;
                if (done_count >= n_faces)
                begin
                    body_phase = PH_DONE;
                    r.fin      = 1'b1;
                end
                else
                    body_phase = PH_FCOUNT;
            end
        end
        pending_results = {pending_results, r};
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge, predict on the
    // input side, check against the oldest expectation on the output side.
    // Also runs the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_body_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected word, expected none, actual kind %0d %h %h %h %s %0d",
                             $time, m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                             "last", m_tlast);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("item_kind", 32'(want.kind), 32'(m_tuser));
                    check_field("word_a", want.word_a, m_tdata[31:0]);
                    check_field("word_b", want.word_b, m_tdata[63:32]);
                    check_field("word_c", want.word_c, m_tdata[95:64]);
                    check_field("final_res", 32'(want.fin), 32'(m_tlast));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[ply_binary_body_triangulator] ERROR");
                $finish;
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // ------------------------------------------------------------------
    // Stimulus helpers. All driving happens at the falling edge.
    // ------------------------------------------------------------------

    // One byte word; idle cycles drawn first at the sender's rate. Leaves
    // tvalid high so the next byte can follow back to back.
    task automatic send_byte(input logic [7:0] data, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop sending, let every expected word come out, then give the
    // pipeline time to swallow bytes that produce nothing.
    task automatic wait_parser_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // only called while idle; model copy is updated along with the block
    task automatic write_count_reg(input logic idx, input logic [CFG_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_VERTEX_COUNT)
            n_vertices = value;
        else
            n_faces = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly short faces, with the below-three counts well represented
    function automatic logic [7:0] rand_corner_count();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return 8'($urandom_range(0, 3));
        if (pick < 9)
            return 8'($urandom_range(4, 6));
        return 8'($urandom_range(7, 40));
    endfunction

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            body_bytes = {body_bytes, w[8*i +: 8]};
    endtask

    task automatic push_vertex();
        repeat (3) push_word(rand_word());
    endtask

    // a face always carries at least three indices
    task automatic push_face(input logic [7:0] corners);
        body_bytes = {body_bytes, corners};
        repeat ((corners > CORNERS) ? corners : CORNERS) push_word(rand_word());
    endtask

    // send the first keep bytes of body_bytes; start flags the first one
    task automatic send_queued(input logic start, input int keep);
        for (int i = 0; i < keep; i++)
        begin
            send_byte(body_bytes[i], start && (i == 0));
            bytes_sent++;
        end
        body_bytes.delete();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset counts (one vertex, no faces): the single vertex is final,
    // trailing bytes are dropped. Extreme coordinate patterns.
    task automatic test_reset_values();
        push_word(32'h0000_0000);
        push_word(32'hFFFF_FFFF);
        push_word(32'h8000_0001);
        send_queued(1'b1, body_bytes.size());
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Zero vertex count still reads one vertex; a face with count byte 0
    // still reads three indices and gives one triangle.
    task automatic test_short_faces();
        wait_parser_idle();
        write_count_reg(CFG_VERTEX_COUNT, '0);
        write_count_reg(CFG_FACE_COUNT, CFG_BITS'(1));
        push_vertex();
        push_face(8'd0);
        send_queued(1'b1, body_bytes.size());
        send_byte(8'hA5, 1'b0);
    endtask

    // Counts at their maximum, then lowered mid-body to no more than what was already
    // done: the section closes on the next vertex / face.
    task automatic test_counts_mid_body();
        wait_parser_idle();
        write_count_reg(CFG_VERTEX_COUNT, '1);
        write_count_reg(CFG_FACE_COUNT, '1);
        push_vertex();
        push_vertex();
        send_queued(1'b1, body_bytes.size());
        wait_parser_idle();
        write_count_reg(CFG_VERTEX_COUNT, CFG_BITS'(1));
        push_vertex();
        push_face(8'd4);
        send_queued(1'b0, body_bytes.size());
        wait_parser_idle();
        write_count_reg(CFG_FACE_COUNT, CFG_BITS'(1));
        push_face(8'd2);
        send_queued(1'b0, body_bytes.size());
        send_byte(rand_byte(), 1'b0);
    endtask

    // Mostly well-formed bodies with random content and counts; some are
    // cut short by the next body start, some followed by junk bytes.
    task automatic test_random_bodies(input int quota);
        int target;
        target = bytes_sent + quota;
        while (bytes_sent < target)
        begin
            if ($urandom_range(2) != 0)
            begin
                wait_parser_idle();
                write_count_reg(CFG_VERTEX_COUNT, ($urandom_range(9) == 0) ?
                                CFG_BITS'($urandom_range(5, 24)) :
                                CFG_BITS'($urandom_range(0, 3)));
                write_count_reg(CFG_FACE_COUNT, ($urandom_range(9) == 0) ?
                                CFG_BITS'($urandom_range(5, 12)) :
                                CFG_BITS'($urandom_range(0, 4)));
            end
            // line noise, start flags included
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 20)) send_byte(rand_byte(), 1'($urandom_range(1)));
            repeat ((n_vertices == '0) ? 1 : n_vertices) push_vertex();
            repeat (n_faces) push_face(rand_corner_count());
            if ($urandom_range(7) == 0)
                send_queued(1'b1, $urandom_range(1, body_bytes.size()));
            else
            begin
                send_queued(1'b1, body_bytes.size());
                repeat ($urandom_range(0, 2)) send_byte(rand_byte(), 1'b0);
            end
        end
    endtask

    initial
    begin
        reset_parser_model();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 27;
        recv_idle_pct = 47;
        test_reset_values();
        test_short_faces();
        test_counts_mid_body();
        test_random_bodies(550);

        send_idle_pct = 47;
        recv_idle_pct = 27;
        test_random_bodies(550);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_bodies(550);

        wait_parser_idle();
        repeat (2 * DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[ply_binary_body_triangulator] OK");
        else
            $display("[ply_binary_body_triangulator] ERROR");
        $finish;
    end

endmodule

/* ply_binary_body_triangulator.f */
rtl/pbbt_pkg.sv
rtl/pbbt_parser.sv
rtl/pbbt_out_reg.sv
rtl/ply_binary_body_triangulator.sv
tb/ply_binary_body_triangulator_tb.sv
